### rtl/core/relay_mode_pulse_controller_macros.svh
// ----------------------------------------------------------------------------
// Relay mode pulse controller assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef RELAY_MODE_PULSE_CONTROLLER_MACROS_SVH
`define RELAY_MODE_PULSE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define RMPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RMPC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMPC_ASSERT(label, clk, rst, prop, msg)
`define RMPC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/core/rmpc_pkg.sv
// ----------------------------------------------------------------------------
// Relay mode pulse controller package
// Shared widths, register indexes, mode codes and configuration types.
// ----------------------------------------------------------------------------
package rmpc_pkg;

   localparam int POS_W    = 16;
   localparam int VOL_W    = 32;
   localparam int CNT_W    = 13;
   localparam int CNT_MAX  = (1 << CNT_W) - 1;
   localparam int MODE_W   = 3;
   localparam int MASK_W   = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_POS  = 5;
   localparam int FILL_IDX = 4;

   localparam int DEF_POSITION_BITS     = 16;
   localparam int DEF_SHORT_PULSE_TICKS = 10;
   localparam int DEF_LONG_PULSE_TICKS  = 6000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE     = 3'd0,
      CSR_SERVICE  = 3'd1,
      CSR_FORWARD  = 3'd2,
      CSR_BACKWASH = 3'd3,
      CSR_BRINING  = 3'd4,
      CSR_FILLING  = 3'd5,
      CSR_MASK     = 3'd6,
      CSR_WEIGHT   = 3'd7
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_HOLD     = 3'd0,
      MODE_HALT     = 3'd1,
      MODE_WASH     = 3'd2,
      MODE_VOLUME   = 3'd3,
      MODE_NEIGHBOR = 3'd4
   } mode_type;

   typedef struct packed {
      logic [MODE_W-1:0]               mode;
      logic [NUM_POS-1:0][POS_W-1:0]   positions;
      logic [MASK_W-1:0]               enable_mask;
      logic [VOL_W-1:0]                impulse_weight;
   } cfg_type;

   typedef struct packed {
      logic             process_running;
      logic [POS_W-1:0] step_position;
      logic [VOL_W-1:0] water_volume;
      logic [POS_W-1:0] piston_position;
      logic             piston_arrived;
      logic             softening_task;
   } tick_type;

   typedef struct packed {
      logic             relay_on;
      logic [CNT_W-1:0] ticks_left;
   } result_type;

endpackage

### rtl/core/rmpc_csr.sv
// ----------------------------------------------------------------------------
// Relay mode pulse controller configuration registers
// Holds the mode, step positions, enable mask and impulse weight.
// ----------------------------------------------------------------------------
module rmpc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [rmpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rmpc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output rmpc_pkg::cfg_type                 cfg,
   output logic                              mode_write
);
   import rmpc_pkg::*;

   localparam cfg_type CFG_RESET = '{
      mode:           MODE_HALT,
      positions:      '0,
      enable_mask:    '0,
      impulse_weight: '0
   };

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE:     cfg_in.mode = csr_wdata[MODE_W-1:0];
            CSR_SERVICE:  cfg_in.positions[0] = csr_wdata[POS_W-1:0];
            CSR_FORWARD:  cfg_in.positions[1] = csr_wdata[POS_W-1:0];
            CSR_BACKWASH: cfg_in.positions[2] = csr_wdata[POS_W-1:0];
            CSR_BRINING:  cfg_in.positions[3] = csr_wdata[POS_W-1:0];
            CSR_FILLING:  cfg_in.positions[FILL_IDX] = csr_wdata[POS_W-1:0];
            CSR_MASK:     cfg_in.enable_mask = csr_wdata[MASK_W-1:0];
            CSR_WEIGHT:   cfg_in.impulse_weight = csr_wdata[VOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg        = cfg_ff;
   assign mode_write = csr_write_en && (csr_index == CSR_MODE);

endmodule

### rtl/core/rmpc_core.sv
// ----------------------------------------------------------------------------
// Relay mode pulse controller step logic
// Relay and pulse state with the per-tick mode update.
// ----------------------------------------------------------------------------
`include "relay_mode_pulse_controller_macros.svh"

module rmpc_core #(
   parameter int POSITION_BITS     = rmpc_pkg::DEF_POSITION_BITS,
   parameter int SHORT_PULSE_TICKS = rmpc_pkg::DEF_SHORT_PULSE_TICKS,
   parameter int LONG_PULSE_TICKS  = rmpc_pkg::DEF_LONG_PULSE_TICKS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rmpc_pkg::cfg_type    cfg,
   input  logic                 mode_write,
   input  logic                 step_en,
   input  rmpc_pkg::tick_type   tick,
   output rmpc_pkg::result_type result
);
   import rmpc_pkg::*;

   localparam int CMP_BITS = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;
   localparam int SHORT_SAT = (SHORT_PULSE_TICKS > CNT_MAX) ? CNT_MAX : SHORT_PULSE_TICKS;
   localparam int LONG_SAT  = (LONG_PULSE_TICKS > CNT_MAX) ? CNT_MAX : LONG_PULSE_TICKS;
   localparam logic [CNT_W-1:0] SHORT_LOAD = CNT_W'(SHORT_SAT);
   localparam logic [CNT_W-1:0] LONG_LOAD  = CNT_W'(LONG_SAT);
   localparam logic [CNT_W-1:0] LOAD_MAX   = (SHORT_LOAD > LONG_LOAD) ? SHORT_LOAD : LONG_LOAD;

   logic                relay_ff,   relay_in;
   logic [CNT_W-1:0]    count_ff,   count_in;
   logic                pending_ff, pending_in;
   logic                reload_ff,  reload_in;
   logic [VOL_W-1:0]    vbase_ff,   vbase_in;
   logic                running_ff, running_in;
   logic [CMP_BITS-1:0] piston_ff,  piston_in;

   always_comb begin
      logic [VOL_W-1:0]    vbase;
      logic                was_running;
      logic [CMP_BITS-1:0] last_piston;
      logic [CMP_BITS-1:0] step_pos;
      logic [CMP_BITS-1:0] piston_pos;
      logic [CMP_BITS-1:0] fill_pos;
      logic [VOL_W-1:0]    increase;
      logic                match;
      logic                update_status;
      logic                pulse_done;

      vbase       = reload_ff ? tick.water_volume : vbase_ff;
      was_running = reload_ff ? tick.process_running : running_ff;
      last_piston = reload_ff ? tick.piston_position[CMP_BITS-1:0] : piston_ff;
      step_pos    = tick.step_position[CMP_BITS-1:0];
      piston_pos  = tick.piston_position[CMP_BITS-1:0];
      fill_pos    = cfg.positions[FILL_IDX][CMP_BITS-1:0];
      increase    = tick.water_volume - vbase;
      update_status = 1'b1;
      pulse_done  = 1'b0;
      match       = 1'b0;
      for (int i = 0; i < NUM_POS; i++) begin
         if (cfg.enable_mask[i] && (step_pos == cfg.positions[i][CMP_BITS-1:0])) begin
            match = 1'b1;
         end
      end

      relay_in   = relay_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      vbase_in   = vbase;
      piston_in  = last_piston;

      unique case (cfg.mode)
         MODE_HOLD: ;
         MODE_HALT: relay_in = 1'b0;
         MODE_WASH: relay_in = tick.process_running && match;
         MODE_VOLUME: begin
            if (tick.process_running) begin
               relay_in = 1'b0;
            end else begin
               if (relay_ff) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end else begin
                     relay_in      = 1'b0;
                     update_status = 1'b0;
                     pulse_done    = 1'b1;
                  end
               end
               if (!pulse_done && (increase > cfg.impulse_weight)) begin
                  relay_in = 1'b1;
                  count_in = SHORT_LOAD;
                  vbase_in = tick.water_volume;
               end
            end
         end
         MODE_NEIGHBOR: begin
            if (tick.softening_task) begin
               if (tick.piston_arrived && (piston_pos == fill_pos) &&
                   (last_piston != fill_pos)) begin
                  pending_in = 1'b1;
               end
               piston_in = piston_pos;
            end else if (!tick.process_running && was_running) begin
               pending_in = 1'b1;
            end
            if (pending_in && !relay_ff) begin
               count_in = LONG_LOAD;
               relay_in = 1'b1;
            end else if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end else begin
               pending_in = 1'b0;
               relay_in   = 1'b0;
            end
         end
         default: ;
      endcase

      running_in = update_status ? tick.process_running : was_running;
      reload_in  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff   <= 1'b0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
         reload_ff  <= 1'b1;
      end else if (mode_write) begin
         relay_ff   <= 1'b0;
         pending_ff <= 1'b0;
         reload_ff  <= 1'b1;
      end else if (step_en) begin
         relay_ff   <= relay_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         reload_ff  <= reload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && !mode_write) begin
         vbase_ff   <= vbase_in;
         running_ff <= running_in;
         piston_ff  <= piston_in;
      end
   end

   assign result.relay_on   = relay_in;
   assign result.ticks_left = count_in;

   `RMPC_ASSERT(a_mode_write_relay_off, clock, reset, mode_write |=> !relay_ff, "relay on after mode write")
   `RMPC_ASSERT(a_count_bound, clock, reset, count_ff <= LOAD_MAX, "pulse counter above load value")
   `RMPC_ASSERT(a_halt_off, clock, reset, (step_en && !mode_write && cfg.mode == MODE_HALT) |=> !relay_ff, "relay on in halt mode")

endmodule

### rtl/core/relay_mode_pulse_controller.sv
// ----------------------------------------------------------------------------
// Relay mode pulse controller
// Drives one relay from control ticks in one of five modes.
// ----------------------------------------------------------------------------
// Each request transaction carries one control tick with the process status;
// each produces exactly one response transaction with the relay level and the
// remaining pulse count after that tick. Both channels use valid and stall.
// A tick is captured in an input register, processed by combinational step
// logic and written to a result register, from which the response is sent.
// One tick is accepted every cycle unless the receiver stalls; the state
// registers update together with the result register, so each tick sees the
// state left by the previous one. When the receiver stalls, the result register
// holds, the input register fills and then the request side stalls.
// The user must write configuration via the csr port only while no transaction
// is in flight; the block does not enforce it. Reset sets halt mode, relay off,
// pulse counter cleared and baselines to reload from the first tick; a mode
// write does the same but keeps the counter and sets the written mode.
// ----------------------------------------------------------------------------
module relay_mode_pulse_controller #(
   parameter int POSITION_BITS     = rmpc_pkg::DEF_POSITION_BITS,
   parameter int SHORT_PULSE_TICKS = rmpc_pkg::DEF_SHORT_PULSE_TICKS,
   parameter int LONG_PULSE_TICKS  = rmpc_pkg::DEF_LONG_PULSE_TICKS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_process_running,
   input  logic [rmpc_pkg::POS_W-1:0]       req_step_position,
   input  logic [rmpc_pkg::VOL_W-1:0]       req_water_volume,
   input  logic [rmpc_pkg::POS_W-1:0]       req_piston_position,
   input  logic                             req_piston_arrived,
   input  logic                             req_softening_task,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_relay_on,
   output logic [rmpc_pkg::CNT_W-1:0]       rsp_ticks_left,
   input  logic                             csr_write_en,
   input  logic [rmpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rmpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rmpc_pkg::*;

   cfg_type    cfg;
   logic       mode_write;
   tick_type   tick_ff;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   result_type result;
   result_type result_ff;
   logic       advance;
   logic       accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tick_ff.process_running <= req_process_running;
         tick_ff.step_position   <= req_step_position;
         tick_ff.water_volume    <= req_water_volume;
         tick_ff.piston_position <= req_piston_position;
         tick_ff.piston_arrived  <= req_piston_arrived;
         tick_ff.softening_task  <= req_softening_task;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   rmpc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .mode_write   (mode_write)
   );

   rmpc_core #(
      .POSITION_BITS     (POSITION_BITS),
      .SHORT_PULSE_TICKS (SHORT_PULSE_TICKS),
      .LONG_PULSE_TICKS  (LONG_PULSE_TICKS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .mode_write (mode_write),
      .step_en    (advance),
      .tick       (tick_ff),
      .result     (result)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_relay_on   = result_ff.relay_on;
   assign rsp_ticks_left = result_ff.ticks_left;

endmodule
